### sv/qau_pkg.sv
// qau_pkg: shared types and constants for the quaternion arithmetic unit
// transaction payload structs and operation codes; no dependencies

package qau_pkg;

    localparam int QAU_COMP_WIDTH = 16;
    localparam int QAU_FRAC_BITS  = 13;

    typedef enum logic [2:0] {
        KIND_PRODUCT   = 3'd0,
        KIND_ADD       = 3'd1,
        KIND_SUBTRACT  = 3'd2,
        KIND_SCALE     = 3'd3,
        KIND_DOT       = 3'd4,
        KIND_CONJUGATE = 3'd5,
        KIND_NEGATE    = 3'd6
    } t_qau_kind;

    typedef struct packed {
        t_qau_kind                        kind;
        logic signed [QAU_COMP_WIDTH-1:0] a_x;
        logic signed [QAU_COMP_WIDTH-1:0] a_y;
        logic signed [QAU_COMP_WIDTH-1:0] a_z;
        logic signed [QAU_COMP_WIDTH-1:0] a_w;
        logic signed [QAU_COMP_WIDTH-1:0] b_x;
        logic signed [QAU_COMP_WIDTH-1:0] b_y;
        logic signed [QAU_COMP_WIDTH-1:0] b_z;
        logic signed [QAU_COMP_WIDTH-1:0] b_w;
        logic signed [QAU_COMP_WIDTH-1:0] scale_factor;
    } t_qau_in;

    typedef struct packed {
        logic signed [QAU_COMP_WIDTH-1:0] out_x;
        logic signed [QAU_COMP_WIDTH-1:0] out_y;
        logic signed [QAU_COMP_WIDTH-1:0] out_z;
        logic signed [QAU_COMP_WIDTH-1:0] out_w;
        logic                             saturated;
    } t_qau_out;

endpackage

### sv/quaternion_arithmetic_unit.sv
// quaternion_arithmetic_unit: hamilton product, add, subtract, scale, dot,
// conjugate and negate on signed fixed point quaternions, saturated results
// depends on qau_pkg
//
//  channel   direction  handshake               payload
//  command   in         start, busy             i_data   (t_qau_in)
//  result    out        o_valid, one-cycle      o_result (t_qau_out)
//
// one transaction per cycle; the result strobe follows acceptance through the input, product and result registers
// stages: input register, sixteen multipliers into a product register,
// sum/round/clip into the result register; the multiplier stage sets the pace
// busy stays low; the receiver cannot stall, results are never held
// synchronous active-low reset clears the valid pipeline only

module quaternion_arithmetic_unit #(
    parameter int FRAC_BITS = qau_pkg::QAU_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  qau_pkg::t_qau_in  i_data,
    output logic              o_valid,
    output qau_pkg::t_qau_out o_result
);
    import qau_pkg::*;

    localparam int W  = QAU_COMP_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam int LW = W + 1;

    // lane order x, y, z, w; slot operands of the hamilton product
    localparam logic [1:0] A_IDX [4][4] = '{
        '{2'd3, 2'd0, 2'd1, 2'd2},
        '{2'd3, 2'd0, 2'd1, 2'd2},
        '{2'd3, 2'd0, 2'd1, 2'd2},
        '{2'd3, 2'd0, 2'd1, 2'd2}
    };
    localparam logic [1:0] B_IDX [4][4] = '{
        '{2'd0, 2'd3, 2'd2, 2'd1},
        '{2'd1, 2'd2, 2'd3, 2'd0},
        '{2'd2, 2'd1, 2'd0, 2'd3},
        '{2'd3, 2'd0, 2'd1, 2'd2}
    };
    localparam logic NEG [4][4] = '{
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b1, 1'b0},
        '{1'b0, 1'b1, 1'b1, 1'b1}
    };

    localparam logic signed [SW-1:0] MAX_V = SW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [SW-1:0] MIN_V = -MAX_V - SW'(1);
    localparam logic signed [SW-1:0] HALF  = SW'(64'd1 << (FRAC_BITS - 1));

    logic                   accept;
    logic                   r_v1, r_v2, r_v3;
    t_qau_in                r_in;
    logic signed [PW-1:0]   r_prod [4][4];
    logic signed [PW-1:0]   n_prod [4][4];
    logic                   r_neg  [4][4];
    logic                   n_neg  [4][4];
    logic signed [LW-1:0]   r_lin  [4];
    logic signed [LW-1:0]   n_lin  [4];
    logic                   r_use_prod;
    logic                   n_use_prod;
    t_qau_out               r_out;
    t_qau_out               n_out;

    logic signed [W-1:0]    a [4];
    logic signed [W-1:0]    b [4];
    logic signed [SW-1:0]   res [4];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign a[0] = r_in.a_x;
    assign a[1] = r_in.a_y;
    assign a[2] = r_in.a_z;
    assign a[3] = r_in.a_w;
    assign b[0] = r_in.b_x;
    assign b[1] = r_in.b_y;
    assign b[2] = r_in.b_z;
    assign b[3] = r_in.b_w;

    // operand selection and multiply
    always_comb begin
        logic signed [W-1:0] opa;
        logic signed [W-1:0] opb;
        n_use_prod = 1'b0;
        for (int k = 0; k < 4; k++) begin
            n_lin[k] = '0;
            for (int s = 0; s < 4; s++) begin
                opa = '0;
                opb = '0;
                n_neg[k][s] = 1'b0;
                unique case (r_in.kind)
                    KIND_PRODUCT: begin
                        opa = a[A_IDX[k][s]];
                        opb = b[B_IDX[k][s]];
                        n_neg[k][s] = NEG[k][s];
                    end
                    KIND_DOT: begin
                        if (k == 3) begin
                            opa = a[A_IDX[k][s]];
                            opb = b[B_IDX[k][s]];
                        end
                    end
                    KIND_SCALE: begin
                        if (s == 0) begin
                            opa = a[k];
                            opb = r_in.scale_factor;
                        end
                    end
                    default: begin
                    end
                endcase
                n_prod[k][s] = PW'(opa) * PW'(opb);
            end
            unique case (r_in.kind)
                KIND_ADD:       n_lin[k] = LW'(a[k]) + LW'(b[k]);
                KIND_SUBTRACT:  n_lin[k] = LW'(a[k]) - LW'(b[k]);
                KIND_CONJUGATE: n_lin[k] = (k == 3) ? LW'(a[k]) : -LW'(a[k]);
                KIND_NEGATE:    n_lin[k] = -LW'(a[k]);
                default:        n_lin[k] = '0;
            endcase
        end
        unique case (r_in.kind)
            KIND_PRODUCT, KIND_DOT, KIND_SCALE: n_use_prod = 1'b1;
            default:                            n_use_prod = 1'b0;
        endcase
    end

    // sum of products with round half up, or the linear result, then saturate
    always_comb begin
        logic signed [SW-1:0] acc;
        logic signed [SW-1:0] val;
        logic                 flag;
        flag = 1'b0;
        for (int k = 0; k < 4; k++) begin
            acc = '0;
            for (int s = 0; s < 4; s++) begin
                acc = r_neg[k][s] ? acc - SW'(r_prod[k][s]) : acc + SW'(r_prod[k][s]);
            end
            val = r_use_prod ? ((acc + HALF) >>> FRAC_BITS) : SW'(r_lin[k]);
            if (val > MAX_V) begin
                val  = MAX_V;
                flag = 1'b1;
            end else if (val < MIN_V) begin
                val  = MIN_V;
                flag = 1'b1;
            end
            res[k] = val;
        end
        n_out.out_x     = res[0][W-1:0];
        n_out.out_y     = res[1][W-1:0];
        n_out.out_z     = res[2][W-1:0];
        n_out.out_w     = res[3][W-1:0];
        n_out.saturated = flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (accept) begin
            r_in <= i_data;
        end
        r_prod     <= n_prod;
        r_neg      <= n_neg;
        r_lin      <= n_lin;
        r_use_prod <= n_use_prod;
        r_out      <= n_out;
    end

    assign o_valid  = r_v3;
    assign o_result = r_out;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_valid)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 3))
        else $error("result without accepted transaction");

    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.saturated) |->
            (o_result.out_x == MAX_V[W-1:0] || o_result.out_x == MIN_V[W-1:0] ||
             o_result.out_y == MAX_V[W-1:0] || o_result.out_y == MIN_V[W-1:0] ||
             o_result.out_z == MAX_V[W-1:0] || o_result.out_z == MIN_V[W-1:0] ||
             o_result.out_w == MAX_V[W-1:0] || o_result.out_w == MIN_V[W-1:0]))
        else $error("saturation flag without a clipped component");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for quaternion_arithmetic_unit
// directed and random command transactions, predicted results compared field by field
// depends on qau_pkg and quaternion_arithmetic_unit

module tb_top;

    import qau_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int ONE          = 1 << QAU_FRAC_BITS;
    localparam int HALF         = 1 << (QAU_FRAC_BITS - 1);

    localparam logic signed [QAU_COMP_WIDTH-1:0] COMP_MAX = 16'sh7fff;
    localparam logic signed [QAU_COMP_WIDTH-1:0] COMP_MIN = 16'sh8000;
    localparam t_qau_kind KIND_UNUSED = t_qau_kind'(3'd7);

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_qau_in   i_data;
    logic      o_valid;
    t_qau_out  o_result;

    t_qau_out  pending_results [$];
    int        error_count;
    int        sender_idle_pct;
    int        cycle_count;

    quaternion_arithmetic_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_data   (i_data),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic longint round_frac(input longint v);
        return (v + HALF) >>> QAU_FRAC_BITS;
    endfunction

    function automatic logic signed [QAU_COMP_WIDTH-1:0] saturate(input longint v,
                                                                  inout bit clipped);
        if (v > COMP_MAX) begin
            clipped = 1'b1;
            return COMP_MAX;
        end
        if (v < COMP_MIN) begin
            clipped = 1'b1;
            return COMP_MIN;
        end
        return v[QAU_COMP_WIDTH-1:0];
    endfunction

    function automatic t_qau_out predict_quaternion_op(input t_qau_in cmd);
        longint   ax, ay, az, aw, bx, by, bz, bw, sc;
        longint   r [4];
        bit       clipped;
        t_qau_out res;
        ax = cmd.a_x; ay = cmd.a_y; az = cmd.a_z; aw = cmd.a_w;
        bx = cmd.b_x; by = cmd.b_y; bz = cmd.b_z; bw = cmd.b_w;
        sc = cmd.scale_factor;
        r = '{default: 0};
        clipped = 1'b0;
        case (cmd.kind)
            KIND_PRODUCT: begin
                r[0] = round_frac(aw * bx + ax * bw + ay * bz - az * by);
                r[1] = round_frac(aw * by - ax * bz + ay * bw + az * bx);
                r[2] = round_frac(aw * bz + ax * by - ay * bx + az * bw);
                r[3] = round_frac(aw * bw - ax * bx - ay * by - az * bz);
            end
            KIND_ADD: begin
                r[0] = ax + bx; r[1] = ay + by; r[2] = az + bz; r[3] = aw + bw;
            end
            KIND_SUBTRACT: begin
                r[0] = ax - bx; r[1] = ay - by; r[2] = az - bz; r[3] = aw - bw;
            end
            KIND_SCALE: begin
                r[0] = round_frac(ax * sc);
                r[1] = round_frac(ay * sc);
                r[2] = round_frac(az * sc);
                r[3] = round_frac(aw * sc);
            end
            KIND_DOT: begin
                r[3] = round_frac(ax * bx + ay * by + az * bz + aw * bw);
            end
            KIND_CONJUGATE: begin
                r[0] = -ax; r[1] = -ay; r[2] = -az; r[3] = aw;
            end
            KIND_NEGATE: begin
                r[0] = -ax; r[1] = -ay; r[2] = -az; r[3] = -aw;
            end
            default: ;
        endcase
        res.out_x     = saturate(r[0], clipped);
        res.out_y     = saturate(r[1], clipped);
        res.out_z     = saturate(r[2], clipped);
        res.out_w     = saturate(r[3], clipped);
        res.saturated = clipped;
        return res;
    endfunction

    function automatic t_qau_in make_command(input t_qau_kind kind,
                                             input int ax, input int ay,
                                             input int az, input int aw,
                                             input int bx, input int by,
                                             input int bz, input int bw,
                                             input int sc);
        t_qau_in cmd;
        cmd.kind = kind;
        cmd.a_x = ax[15:0]; cmd.a_y = ay[15:0]; cmd.a_z = az[15:0]; cmd.a_w = aw[15:0];
        cmd.b_x = bx[15:0]; cmd.b_y = by[15:0]; cmd.b_z = bz[15:0]; cmd.b_w = bw[15:0];
        cmd.scale_factor = sc[15:0];
        return cmd;
    endfunction

    function automatic logic signed [QAU_COMP_WIDTH-1:0] random_component();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2, 3: return 16'($urandom);
            4, 5, 6, 7: return 16'($urandom_range(2 * ONE) - ONE);
            8: begin
                case ($urandom_range(4))
                    0: return COMP_MIN;
                    1: return COMP_MAX;
                    2: return '0;
                    3: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            default: return 16'($urandom_range(32) - 16);
        endcase
    endfunction

    task automatic issue_command(input t_qau_in cmd);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        start  <= 1'b1;
        i_data <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(predict_quaternion_op(cmd));
    endtask

    task automatic test_extremes();
        issue_command(make_command(KIND_PRODUCT, 32767, 32767, 32767, 32767,
                                   32767, 32767, 32767, 32767, 0));
        issue_command(make_command(KIND_PRODUCT, -32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768, -32768));
        issue_command(make_command(KIND_ADD, 32767, 32767, -32768, -32768,
                                   32767, 1, -32768, -1, 0));
        issue_command(make_command(KIND_SUBTRACT, -32768, 32767, 0, -32768,
                                   32767, -32768, -32768, 1, 0));
        issue_command(make_command(KIND_SCALE, -32768, 32767, -32768, 1,
                                   0, 0, 0, 0, -32768));
        issue_command(make_command(KIND_SCALE, 32767, -32768, 32767, -1,
                                   0, 0, 0, 0, 32767));
        issue_command(make_command(KIND_DOT, -32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768, 0));
    endtask

    task automatic test_each_operation();
        issue_command(make_command(KIND_PRODUCT, 0, 0, 0, ONE,
                                   1234, -2345, 3456, -4567, 0));
        issue_command(make_command(KIND_PRODUCT, ONE, 0, 0, 0, 0, ONE, 0, 0, 0));
        issue_command(make_command(KIND_ADD, 100, -200, 300, -400, 5, 6, 7, 8, 0));
        issue_command(make_command(KIND_SUBTRACT, 100, -200, 300, -400, 5, 6, 7, 8, 0));
        issue_command(make_command(KIND_SCALE, 1000, -2000, 3000, ONE,
                                   0, 0, 0, 0, ONE / 2));
        issue_command(make_command(KIND_DOT, ONE, 0, ONE / 2, 0,
                                   ONE, 7, ONE, 9, 0));
        issue_command(make_command(KIND_CONJUGATE, 111, -222, 333, -444, 0, 0, 0, 0, 0));
        issue_command(make_command(KIND_NEGATE, 111, -222, 333, -444, 0, 0, 0, 0, 0));
    endtask

    task automatic test_special_cases();
        // most negative value under negate and conjugate
        issue_command(make_command(KIND_NEGATE, -32768, -32768, -32768, -32768,
                                   0, 0, 0, 0, 0));
        issue_command(make_command(KIND_CONJUGATE, -32768, 5, -32768, -32768,
                                   0, 0, 0, 0, 0));
        // unused operation code
        issue_command(make_command(KIND_UNUSED, 32767, -32768, 1, -1,
                                   32767, -32768, 1, -1, 32767));
        // rounding exactly at half an lsb
        issue_command(make_command(KIND_SCALE, 1, -1, 3, -3, 0, 0, 0, 0, HALF));
        issue_command(make_command(KIND_DOT, 1, -1, 0, 0, HALF, HALF, 0, 0, 0));
        issue_command(make_command(KIND_PRODUCT, 1, 1, 1, 1, HALF, HALF, HALF, HALF, 0));
    endtask

    task automatic test_random(input int count, input int idle_pct);
        t_qau_in cmd;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            cmd.kind = ($urandom_range(99) < 2) ? KIND_UNUSED
                                                : t_qau_kind'($urandom_range(6));
            cmd.a_x = random_component(); cmd.a_y = random_component();
            cmd.a_z = random_component(); cmd.a_w = random_component();
            cmd.b_x = random_component(); cmd.b_y = random_component();
            cmd.b_z = random_component(); cmd.b_w = random_component();
            cmd.scale_factor = random_component();
            issue_command(cmd);
        end
    endtask

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (got !== want) begin
            $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_qau_out want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected transaction expected none actual %p",
                         $time, o_result);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("out_x", want.out_x, o_result.out_x);
                report_field("out_y", want.out_y, o_result.out_y);
                report_field("out_z", want.out_z, o_result.out_z);
                report_field("out_w", want.out_w, o_result.out_w);
                report_field("saturated", 16'(want.saturated), 16'(o_result.saturated));
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_data          = '0;
        error_count     = 0;
        sender_idle_pct = 14;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_each_operation();
        test_special_cases();
        test_random(650, 14);
        test_random(650, 86);
        test_random(650, 0);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
